FILE: rtl/core/ptb_pkg.sv
// shared types, codes and sizes for the two-level page table engine
`default_nettype none

package ptb_pkg;

	localparam int unsigned DEFAULT_TABLE_SLOTS = 16;
	localparam int unsigned CMD_DEPTH = 2;
	localparam int unsigned RES_DEPTH = 2;
	localparam int unsigned DIR_ENTRIES = 1024;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned FRAME_W = 20;
	localparam int unsigned ENT_W = FRAME_W + 3;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [1:0] MODE_MAP = 2'd0;
	localparam logic [1:0] MODE_UNMAP = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_MISALIGNED = 2'd1;
	localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

	localparam logic REG_TABLE_BASE = 1'b0;

	typedef enum logic [1:0] {
		OP_MAP,
		OP_UNMAP,
		OP_LOOKUP,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] virt_addr;
		logic [31:0] phys_addr;
		logic [2:0] access_flags;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] phys_page;
		logic overwrote;
	} out_item_t;

	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] dir_idx;
		logic [IDX_W-1:0] tbl_idx;
		logic [FRAME_W-1:0] frame;
		logic user;
		logic writable;
		logic [1:0] status;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);
	localparam int unsigned RES_W = $bits(out_item_t);

endpackage

`default_nettype wire

FILE: rtl/core/ptb_fifo.sv
// small register-based first-in first-out queue
`default_nettype none

module ptb_fifo #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ptb_front.sv
// front end: accepts request beats, checks alignment, queues commands
`default_nettype none

module ptb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ptb_pkg::in_item_t request,
	input  logic              hold,
	output logic              full,
	output ptb_pkg::cmd_t     cmd,
	output logic              cmd_valid,
	input  logic              cmd_pop
);
	import ptb_pkg::*;

	cmd_t cls;
	logic pa_mis;
	logic va_mis;
	logic fifo_full;
	logic fifo_empty;
	logic [CMD_W-1:0] rd_bits;

	always_comb begin
		pa_mis = |request.phys_addr[11:0];
		va_mis = |request.virt_addr[11:0];
		cls.dir_idx = request.virt_addr[31:22];
		cls.tbl_idx = request.virt_addr[21:12];
		cls.frame = request.phys_addr[31:12];
		cls.writable = |request.access_flags[1:0];
		cls.user = ~request.access_flags[2];
		cls.status = STATUS_OK;
		cls.op = OP_DONE;
		case (request.mode)
			MODE_MAP: begin
				if (pa_mis || va_mis) begin
					cls.status = STATUS_MISALIGNED;
				end else begin
					cls.op = OP_MAP;
				end
			end
			MODE_UNMAP: begin
				if (va_mis) begin
					cls.status = STATUS_MISALIGNED;
				end else begin
					cls.op = OP_UNMAP;
				end
			end
			MODE_LOOKUP: begin
				cls.op = OP_LOOKUP;
			end
			default: begin
				cls.op = OP_DONE;
			end
		endcase
	end

	assign full = fifo_full || hold;
	assign cmd = cmd_t'(rd_bits);
	assign cmd_valid = !fifo_empty;

	ptb_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && !full),
		.wr_data(CMD_W'(cls)),
		.rd_en  (cmd_pop),
		.rd_data(rd_bits),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

endmodule

`default_nettype wire

FILE: rtl/core/ptb_back.sv
// back end: directory and table memories, slot allocator, walk sequencer
`default_nettype none

module ptb_back #(
	parameter int unsigned TABLE_SLOTS = ptb_pkg::DEFAULT_TABLE_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptb_pkg::cmd_t                cmd,
	input  logic                         cmd_valid,
	output logic                         cmd_pop,
	input  logic                         res_room,
	output logic                         res_push,
	output ptb_pkg::out_item_t           res,
	output logic                         clearing
);
	import ptb_pkg::*;

	localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned TBL_DEPTH = TABLE_SLOTS * DIR_ENTRIES;
	localparam int unsigned TA_W = $clog2(TBL_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIR,
		ST_TBL
	} state_t;

	logic [SLOT_W:0] dir_mem [DIR_ENTRIES];
	logic [ENT_W-1:0] tbl_mem [TBL_DEPTH];

	state_t state_q;
	cmd_t cmd_q;
	logic [CNT_W-1:0] next_slot_q;
	logic [TA_W-1:0] taddr_q;
	logic clr_q;
	logic [TA_W-1:0] clr_cnt_q;
	logic [SLOT_W:0] dir_rdata_q;
	logic [ENT_W-1:0] tbl_rdata_q;

	logic dir_we;
	logic [IDX_W-1:0] dir_waddr;
	logic [SLOT_W:0] dir_wdata;
	logic tbl_we;
	logic [TA_W-1:0] tbl_waddr;
	logic [ENT_W-1:0] tbl_wdata;
	logic [TA_W-1:0] tbl_raddr;
	logic present;
	logic need_alloc;
	logic exhausted;
	logic do_alloc;
	logic tbl_access;
	logic [SLOT_W-1:0] slot_sel;
	logic [ENT_W-1:0] new_ent;

	assign clearing = clr_q;
	assign cmd_pop = (state_q == ST_IDLE) && !clr_q && cmd_valid && res_room;

	always_comb begin
		present = dir_rdata_q[SLOT_W];
		need_alloc = (cmd_q.op == OP_MAP) && !present;
		exhausted = need_alloc && (next_slot_q == CNT_W'(TABLE_SLOTS));
		do_alloc = need_alloc && !exhausted;
		tbl_access = present || do_alloc;
		slot_sel = present ? dir_rdata_q[SLOT_W-1:0] : next_slot_q[SLOT_W-1:0];
		tbl_raddr = TA_W'({slot_sel, cmd_q.tbl_idx});
		new_ent = {cmd_q.frame, cmd_q.user, cmd_q.writable, 1'b1};

		dir_we = 1'b0;
		dir_waddr = cmd_q.dir_idx;
		dir_wdata = {1'b1, next_slot_q[SLOT_W-1:0]};
		tbl_we = 1'b0;
		tbl_waddr = taddr_q;
		tbl_wdata = new_ent;
		res_push = 1'b0;
		res.status = STATUS_OK;
		res.phys_page = '0;
		res.overwrote = 1'b0;

		if (clr_q) begin
			dir_we = 1'b1;
			dir_waddr = clr_cnt_q[IDX_W-1:0];
			dir_wdata = '0;
			tbl_we = 1'b1;
			tbl_waddr = clr_cnt_q;
			tbl_wdata = '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.op == OP_DONE)) begin
						res_push = 1'b1;
						res.status = cmd.status;
					end
				end
				ST_DIR: begin
					dir_we = do_alloc;
					if (!tbl_access) begin
						res_push = 1'b1;
						res.status = exhausted ? STATUS_NO_SLOT : STATUS_OK;
					end
				end
				ST_TBL: begin
					res_push = 1'b1;
					case (cmd_q.op)
						OP_MAP: begin
							tbl_we = 1'b1;
							res.overwrote = tbl_rdata_q[0] && (tbl_rdata_q != new_ent);
						end
						OP_UNMAP: begin
							tbl_we = 1'b1;
							tbl_wdata = {tbl_rdata_q[ENT_W-1:1], 1'b0};
						end
						OP_LOOKUP: begin
							if (tbl_rdata_q[0]) begin
								res.phys_page = {tbl_rdata_q[ENT_W-1:3], 12'h000};
							end
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
				default: begin
					res_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_slot_q <= '0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (clr_q) begin
				if (clr_cnt_q == TA_W'(TBL_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + TA_W'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.op != OP_DONE)) begin
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					if (do_alloc) begin
						next_slot_q <= next_slot_q + CNT_W'(1);
					end
					state_q <= tbl_access ? ST_TBL : ST_IDLE;
				end
				ST_TBL: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_DIR) begin
			taddr_q <= tbl_raddr;
		end
	end

	// directory entry: present bit and slot of its table
	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rdata_q <= dir_mem[cmd.dir_idx];
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rdata_q <= tbl_mem[tbl_raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/two_level_page_table_engine.sv
// two-level page table engine top level with configuration port
// Requests enter through a queue-style port: a beat is taken when push is
// high and full is low. Each request maps, unmaps or looks up one 4 KiB page.
// Exactly one response beat follows per request, in order; it sits on
// response while empty is low and leaves when pop is high.
// A command queue decouples request intake from the walk sequencer, and a
// result queue decouples the sequencer from the response side, so a stalled
// receiver only stops intake once both queues fill.
// The sequencer pops a command only from idle with result-queue room, so a walk
// that touches a page table (directory read, then table read-modify-write in
// synchronous memories) or finds the directory entry absent ends before the
// next begins; misaligned requests and unused modes are answered from idle.
// With the sequencer idle, a request passes through the command queue, the
// sequencer and the result queue before its response is visible.
// After reset the directory and the page-table store are zeroed by a sweep
// over every table address; full stays high during the sweep.
// table_base_frame is written over the APB port (address 0); write it only while
// idle (not enforced by the block). It is only read back; no walk uses it.
`default_nettype none

module two_level_page_table_engine #(
	parameter int unsigned TABLE_SLOTS = ptb_pkg::DEFAULT_TABLE_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  ptb_pkg::in_item_t              request,
	output logic                           empty,
	input  logic                           pop,
	output ptb_pkg::out_item_t             response,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import ptb_pkg::*;

	logic [FRAME_W-1:0] base_frame_q;
	logic hold;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	logic res_push;
	out_item_t res;
	logic res_full;
	logic [RES_W-1:0] res_bits;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TABLE_BASE) ? {12'h000, base_frame_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frame_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TABLE_BASE)) begin
			base_frame_q <= pwdata[FRAME_W-1:0];
		end
	end

	ptb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.hold     (hold),
		.full     (full),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop)
	);

	ptb_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.res_room        (!res_full),
		.res_push        (res_push),
		.res             (res),
		.clearing        (hold)
	);

	ptb_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(RES_W'(res)),
		.rd_en  (pop),
		.rd_data(res_bits),
		.full   (res_full),
		.empty  (empty)
	);

	assign response = out_item_t'(res_bits);

endmodule

`default_nettype wire

FILE: bench/tb_two_level_page_table_engine.sv
// self-checking bench for the two-level page table engine: directed, random and stall traffic
module tb_two_level_page_table_engine;
	import ptb_pkg::*;

	localparam int unsigned SLOTS = DEFAULT_TABLE_SLOTS;
	localparam int unsigned HOT_PAGES = 24;
	localparam int unsigned RX_HOLD = 400;
	localparam int unsigned QUIET_LIMIT = 50000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [31:0] PAGE_MASK = 32'hFFFFF000;
	localparam logic [APB_ADDR_W-1:0] TABLE_BASE_ADDR = APB_ADDR_W'(4 * REG_TABLE_BASE);

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t request = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t response;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [31:0] pde [DIR_ENTRIES];
	int unsigned pde_slot [DIR_ENTRIES];
	logic [31:0] pte [SLOTS*DIR_ENTRIES];
	int unsigned tables_made = 0;
	logic [FRAME_W-1:0] base_frame = '0;

	out_item_t pending_resp[$];
	logic [31:0] hot_va [HOT_PAGES];
	logic [31:0] hot_pa [HOT_PAGES];
	logic [9:0] hot_dir [4];

	logic steady = 1'b0;
	int unsigned hold_asks = 0;
	int unsigned holds_done = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	two_level_page_table_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.response(response),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic out_item_t predict_walk(in_item_t req);
		logic [9:0] di;
		logic [9:0] ti;
		logic [31:0] ent;
		logic [31:0] old;
		logic [FRAME_W-1:0] frame;
		int unsigned pos;
		out_item_t res;
		res = '0;
		di = req.virt_addr[31:22];
		ti = req.virt_addr[21:12];
		ent = {req.phys_addr[31:12], 9'd0, ~req.access_flags[2], |req.access_flags[1:0], 1'b1};
		case (req.mode)
			MODE_MAP: begin
				if (req.phys_addr[11:0] != '0 || req.virt_addr[11:0] != '0) begin
					res.status = STATUS_MISALIGNED;
				end else if (!pde[di][0] && tables_made >= SLOTS) begin
					res.status = STATUS_NO_SLOT;
				end else begin
					if (!pde[di][0]) begin
						frame = base_frame + FRAME_W'(tables_made);
						pde_slot[di] = tables_made;
						pde[di] = {frame, ent[11:0]};
						tables_made++;
					end
					pos = pde_slot[di] * DIR_ENTRIES + ti;
					old = pte[pos];
					res.overwrote = old[0] && old != ent;
					pte[pos] = ent;
				end
			end
			MODE_UNMAP: begin
				if (req.virt_addr[11:0] != '0) begin
					res.status = STATUS_MISALIGNED;
				end else if (pde[di][0]) begin
					pos = pde_slot[di] * DIR_ENTRIES + ti;
					pte[pos][0] = 1'b0;
				end
			end
			MODE_LOOKUP: begin
				if (pde[di][0]) begin
					old = pte[pde_slot[di] * DIR_ENTRIES + ti];
					if (old[0])
						res.phys_page = old & PAGE_MASK;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic send_req(logic [1:0] mode, logic [31:0] va, logic [31:0] pa,
			logic [2:0] acc);
		in_item_t beat;
		beat.mode = mode;
		beat.virt_addr = va;
		beat.phys_addr = pa;
		beat.access_flags = acc;
		if (!steady && $urandom_range(99) < 7) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		push <= 1'b1;
		request <= beat;
		do
			@(posedge clk);
		while (full);
		pending_resp.push_back(predict_walk(beat));
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_table_base(logic [FRAME_W-1:0] frame);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= TABLE_BASE_ADDR;
		pwdata <= 32'(frame);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		base_frame = frame;
	endtask

	task automatic t_directed();
		set_table_base('0);
		send_req(MODE_LOOKUP, 32'h00000000, '0, 3'b000);
		send_req(MODE_MAP, 32'h00000000, 32'hFFFFF000, 3'b000);
		send_req(MODE_LOOKUP, 32'h00000FFF, '0, 3'b000);
		send_req(MODE_MAP, 32'h00000000, 32'hFFFFF000, 3'b000);
		send_req(MODE_MAP, 32'h00000000, 32'h12345000, 3'b111);
		send_req(MODE_MAP, 32'hFFFFF000, 32'h00000000, 3'b011);
		send_req(MODE_LOOKUP, 32'hFFFFFABC, '0, 3'b000);
		send_req(MODE_MAP, 32'h00001000, 32'h00000800, 3'b001);
		send_req(MODE_MAP, 32'h00001001, 32'h00001000, 3'b001);
		send_req(MODE_UNMAP, 32'h00000001, '0, 3'b000);
		send_req(MODE_UNMAP, 32'h00002000, '0, 3'b000);
		send_req(MODE_UNMAP, 32'h40000000, '0, 3'b000);
		send_req(MODE_UNMAP, 32'h00000000, '0, 3'b000);
		send_req(MODE_LOOKUP, 32'h00000000, '0, 3'b000);
		send_req(MODE_MAP, 32'h00000000, 32'h12345000, 3'b111);
		send_req(MODE_UNUSED, '1, '1, '1);
		send_req(MODE_LOOKUP, 32'h80000000, '0, 3'b000);
		send_req(MODE_MAP, 32'h556AA000, 32'hAAAAA000, 3'b100);
		send_req(MODE_MAP, 32'hAA955000, 32'h55555000, 3'b010);
		send_req(MODE_MAP, 32'h556AA000, 32'hAAAAA000, 3'b101);
		send_req(MODE_LOOKUP, 32'h556AA123, '0, 3'b000);
		send_req(MODE_LOOKUP, 32'hAA955000, '0, 3'b000);
		send_req(MODE_MAP, 32'hAA955000, 32'h55555000, 3'b110);
		send_req(MODE_UNMAP, 32'hFFFFF000, '0, 3'b000);
		send_req(MODE_LOOKUP, 32'hFFFFF000, '0, 3'b000);
	endtask

	task automatic t_base_wrap();
		set_table_base('1);
		send_req(MODE_MAP, 32'hFF800000, 32'h0F0F0000, 3'b001);
		send_req(MODE_MAP, 32'h007FF000, 32'hF0F0F000, 3'b100);
		send_req(MODE_LOOKUP, 32'hFF800000, '0, 3'b000);
		send_req(MODE_LOOKUP, 32'h007FF000, '0, 3'b000);
	endtask

	task automatic t_random_traffic(int unsigned count);
		logic [1:0] mode;
		logic [31:0] va;
		logic [31:0] pa;
		int unsigned k;
		int unsigned pg;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			mode = k < 35 ? MODE_MAP : k < 55 ? MODE_UNMAP : k < 97 ? MODE_LOOKUP : MODE_UNUSED;
			pg = $urandom_range(HOT_PAGES - 1);
			va = hot_va[pg];
			pa = hot_pa[pg];
			if ($urandom_range(99) < 40) begin
				pa = $urandom & PAGE_MASK;
				hot_pa[pg] = pa;
			end
			if ($urandom_range(99) < 3)
				va = $urandom & PAGE_MASK;
			if ($urandom_range(99) < 8)
				va[11:0] = 12'($urandom);
			if ($urandom_range(99) < 8)
				pa[11:0] = 12'($urandom);
			send_req(mode, va, pa, 3'($urandom));
		end
	endtask

	task automatic t_backpressure();
		hold_asks++;
		t_random_traffic(30);
	endtask

	task automatic t_steady();
		steady = 1'b1;
		t_random_traffic(300);
		steady = 1'b0;
	endtask

	task automatic t_slot_exhaust();
		logic [31:0] va;
		set_table_base(FRAME_W'($urandom));
		for (int d = 'h300; d < 'h320; d++) begin
			va = {10'(d), 10'($urandom), 12'd0};
			send_req(MODE_MAP, va, $urandom & PAGE_MASK, 3'($urandom));
			send_req(MODE_LOOKUP, va, '0, 3'b000);
		end
		send_req(MODE_UNMAP, 32'hC7C00000, '0, 3'b000);
		send_req(MODE_LOOKUP, 32'hC7C00000, '0, 3'b000);
	endtask

	initial begin
		for (int i = 0; i < DIR_ENTRIES; i++) begin
			pde[i] = '0;
			pde_slot[i] = 0;
		end
		for (int i = 0; i < SLOTS * DIR_ENTRIES; i++)
			pte[i] = '0;
		hot_dir[0] = 10'h000;
		hot_dir[1] = 10'h3FF;
		hot_dir[2] = 10'h155;
		hot_dir[3] = 10'h2AA;
		for (int i = 0; i < HOT_PAGES; i++) begin
			hot_va[i] = {hot_dir[i % 4], i < 4 ? {10{i[0]}} : 10'($urandom), 12'd0};
			hot_pa[i] = $urandom & PAGE_MASK;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		t_directed();
		t_base_wrap();
		set_table_base(FRAME_W'($urandom));
		t_random_traffic(700);
		t_backpressure();
		t_steady();
		t_slot_exhaust();
		t_random_traffic(450);
		drain();
		if (errors == 0)
			$display("PASS two_level_page_table_engine");
		else
			$display("FAIL two_level_page_table_engine");
		$finish;
	end

	// receiver side: random pop, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				pop <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end
			pop <= steady || $urandom_range(99) >= 7;
		end
	end

	always @(posedge clk) begin : resp_check
		out_item_t want;
		if (pop && !empty) begin
			if (pending_resp.size() == 0) begin
				$display("%0t response beat with none pending: expected none, actual %h",
					$time, response);
				errors++;
			end else begin
				want = pending_resp.pop_front();
				if (response.status !== want.status) begin
					$display("%0t status mismatch: expected %0d, actual %0d",
						$time, want.status, response.status);
					errors++;
				end
				if (response.phys_page !== want.phys_page) begin
					$display("%0t phys_page mismatch: expected %h, actual %h",
						$time, want.phys_page, response.phys_page);
					errors++;
				end
				if (response.overwrote !== want.overwrote) begin
					$display("%0t overwrote mismatch: expected %0b, actual %0b",
						$time, want.overwrote, response.overwrote);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL two_level_page_table_engine");
			$finish;
		end
	end

endmodule
